>>> rtl/bkscu_pkg.sv
// Package for the bounded key set unit: command and status codes, cell control
// struct and key normalization. No dependencies; used by every rtl file.
`timescale 1ns / 1ps

package bkscu_pkg;

  localparam int KeyW     = 64;
  localparam int KeyChars = 8;
  localparam int CmdW     = 2;
  localparam int StatusW  = 2;
  localparam int CountW   = 5;
  localparam int InDataW  = 72;
  localparam int OutDataW = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_e;

  typedef struct packed {
    logic            ins_commit;
    logic            rem_commit;
    logic [KeyW-1:0] key;
  } cell_ctrl_t;

  // cut at the first zero byte, keep at most KeyChars bytes
  function automatic logic [KeyW-1:0] norm_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    logic            stop;
    r    = '0;
    stop = 1'b0;
    for (int b = 0; b < KeyW / 8; b++) begin
      if (b >= KeyChars || k[8*b +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[8*b +: 8] = k[8*b +: 8];
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/bkscu_cell.sv
// One storage cell of the key chain: holds one key, compares it with the
// current key and takes its neighbor's key on a remove. Depends on bkscu_pkg.
`timescale 1ns / 1ps

module bkscu_cell (
  input  logic                            clk_i,
  input  bkscu_pkg::cell_ctrl_t           ctrl_i,
  input  logic                            occupied_i,
  input  logic                            load_i,
  input  logic [bkscu_pkg::KeyW-1:0]      next_key_i,
  input  logic                            seen_i,
  output logic                            seen_o,
  output logic                            hit_o,
  output logic [bkscu_pkg::KeyW-1:0]      key_o
);
  import bkscu_pkg::*;

  logic [KeyW-1:0] key_q, key_d;

  assign hit_o  = occupied_i && (key_q == ctrl_i.key);
  assign seen_o = seen_i | hit_o;
  assign key_o  = key_q;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins_commit && load_i) begin
      key_d = ctrl_i.key;
    end else if (ctrl_i.rem_commit && seen_o) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

>>> rtl/bounded_key_set_with_compaction_unit.sv
// Top level of the bounded key set: stream ports, command sequencer, count
// and the chain of bkscu_cell storage cells. Depends on bkscu_pkg, bkscu_cell.
`timescale 1ns / 1ps

// Usage:
//   Commands arrive on the s_axis group (cmd and key in tdata); each one gives
//   exactly one result on the m_axis group (status and count_after in tdata).
//   Lookup reports found / not found, insert appends a new key at the end of
//   the list, remove deletes a key and moves every later key down one cell.
//   The input transfer registers the normalized key; in the execute state the
//   unit compares it in all cells at once (the hit ripples down the cell chain),
//   applies the append or shift and registers the result for m_axis once the
//   output register is free. A new command is taken only once the last one has
//   left the execute state.
//   Reset clears the count and the handshake state; stored keys are not
//   cleared, cells above the count are never read.
//   When the receiver stalls, the result waits in the output register; one
//   more command is still taken and then held until the output frees up.
module bounded_key_set_with_compaction_unit #(
  parameter int DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [1:0] cmd, [65:2] key, [71:66] zero
  input  logic [bkscu_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [1:0] status, [6:2] count_after, [7] zero
  output logic [bkscu_pkg::OutDataW-1:0]    m_axis_tdata_o
);
  import bkscu_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  fsm_e            state_q, state_d;
  cmd_e            cmd_q;
  logic [KeyW-1:0] key_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  status_e         out_status_q, status_d;
  logic [CountW-1:0] out_cnt_q;
  logic [CntW+CountW-1:0] cnt_ext;

  logic            in_xfer, commit, found, full, ins_ok, rem_ok;
  cell_ctrl_t      ctrl;
  logic [DEPTH:0]  seen;
  logic [DEPTH-1:0] hit;
  logic [KeyW-1:0] cell_key [DEPTH];

  assign s_axis_tready_o = (state_q == FSM_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = (state_q == FSM_EXEC) && (!out_valid_q || m_axis_tready_i);

  assign found  = seen[DEPTH];
  assign full   = (cnt_q >= CntW'(DEPTH));
  assign ins_ok = commit && (cmd_q == CMD_INSERT) && !full && !found;
  assign rem_ok = commit && (cmd_q == CMD_REMOVE) && found;

  assign ctrl.ins_commit = ins_ok;
  assign ctrl.rem_commit = rem_ok;
  assign ctrl.key        = key_q;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KeyW-1:0] next_key;
    if (i < DEPTH - 1) begin : g_mid
      assign next_key = cell_key[i+1];
    end else begin : g_last
      assign next_key = cell_key[i];
    end
    bkscu_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (CntW'(i) < cnt_q),
      .load_i     (CntW'(i) == cnt_q),
      .next_key_i (next_key),
      .seen_i     (seen[i]),
      .seen_o     (seen[i+1]),
      .hit_o      (hit[i]),
      .key_o      (cell_key[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    status_d    = found ? ST_OK : ST_NOTFOUND;
    unique case (cmd_q)
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (found) begin
          status_d = ST_DUP;
        end else begin
          status_d = ST_OK;
        end
      end
      default: begin
        status_d = found ? ST_OK : ST_NOTFOUND;
      end
    endcase
    unique case (state_q)
      FSM_IDLE: begin
        if (in_xfer) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (commit) begin
          state_d     = FSM_IDLE;
          out_valid_d = 1'b1;
          if (ins_ok) begin
            cnt_d = cnt_q + CntW'(1);
          end else if (rem_ok) begin
            cnt_d = cnt_q - CntW'(1);
          end
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cnt_ext = {{CountW{1'b0}}, cnt_d};

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= cmd_e'(s_axis_tdata_i[CmdW-1:0]);
      key_q <= norm_key(s_axis_tdata_i[CmdW +: KeyW]);
    end
    if (commit) begin
      out_status_q <= status_d;
      out_cnt_q    <= cnt_ext[CountW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_cnt_q, out_status_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("stored count above capacity");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_EXEC) |-> $onehot0(hit))
    else $error("key stored in more than one cell");

  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (m_axis_tvalid_o && state_q == FSM_IDLE))
    else $error("finished command did not load the output register");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_ok |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("insert did not advance the count");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for bounded_key_set_with_compaction_unit: directed and random
// lookup, insert and remove transfers checked against a shadow copy of the key set.
// Depends on bkscu_pkg and the rtl top level.

module testbench;
  import bkscu_pkg::*;

  localparam int SetDepth   = 16;
  localparam int PoolSize   = 24;
  localparam int PhaseLen   = 150;
  localparam int NumPhases  = 12;
  localparam int CycleLimit = 600000;
  localparam int PadW       = InDataW - KeyW - CmdW;

  typedef struct {
    cmd_e            cmd;
    logic [KeyW-1:0] key;
    int unsigned     gap;
    bit              drain_first;
  } set_cmd_t;

  typedef struct {
    status_e           status;
    logic [CountW-1:0] count_after;
  } set_reply_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  set_cmd_t        cmd_q[$];
  set_reply_t      replies_q[$];
  logic [KeyW-1:0] shadow_keys[SetDepth];
  int              shadow_count = 0;
  logic [KeyW-1:0] key_pool[PoolSize];

  bit          phase_calm   = 1'b0;
  bit          in_taken     = 1'b0;
  bit          out_taken    = 1'b0;
  bit          rx_calm      = 1'b0;
  int unsigned gap_count    = 0;
  int unsigned stall_count  = 0;
  int unsigned stall_target = 0;
  int unsigned rx_seen      = 0;
  int          errors       = 0;
  int          cycle_count  = 0;

  bounded_key_set_with_compaction_unit #(
    .DEPTH(SetDepth)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic [KeyW-1:0] canon_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] keep;
    keep = '0;
    for (int b = 0; b < KeyW / 8; b++) begin
      if (b < KeyChars && (b == 0 || keep[8*b-1]) && k[8*b +: 8] != 8'd0) begin
        keep[8*b +: 8] = 8'hFF;
      end
    end
    return k & keep;
  endfunction

  function automatic set_reply_t apply_to_shadow_set(input cmd_e cmd,
                                                     input logic [KeyW-1:0] raw);
    set_reply_t      r;
    logic [KeyW-1:0] k;
    int              pos;
    k   = canon_key(raw);
    pos = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (pos < 0 && shadow_keys[i] == k) begin
        pos = i;
      end
    end
    case (cmd)
      CMD_INSERT: begin
        if (shadow_count >= SetDepth) begin
          r.status = ST_FULL;
        end else if (pos >= 0) begin
          r.status = ST_DUP;
        end else begin
          shadow_keys[shadow_count] = k;
          shadow_count++;
          r.status = ST_OK;
        end
      end
      CMD_REMOVE: begin
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
          end
          shadow_count--;
          r.status = ST_OK;
        end
      end
      default: begin
        r.status = (pos >= 0) ? ST_OK : ST_NOTFOUND;
      end
    endcase
    r.count_after = CountW'(shadow_count);
    return r;
  endfunction

  task automatic check_reply(input logic [OutDataW-1:0] data);
    set_reply_t want;
    if (replies_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual status %0d count %0d",
               $time, data[1:0], data[6:2]);
      errors++;
    end else begin
      want = replies_q.pop_front();
      if (data[1:0] !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, data[1:0]);
        errors++;
      end
      if (data[6:2] !== want.count_after) begin
        $display("%0t: count_after mismatch, expected %0d actual %0d",
                 $time, want.count_after, data[6:2]);
        errors++;
      end
    end
  endtask

  // sample both handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        replies_q.push_back(apply_to_shadow_set(cmd_e'(s_axis_tdata[CmdW-1:0]),
                                                s_axis_tdata[CmdW +: KeyW]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_reply(m_axis_tdata);
      end
    end
    in_taken  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_taken <= rst_ni && m_axis_tvalid && m_axis_tready;
  end

  // sender: hold until transfer, then idle for the next item's gap
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (cmd_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q[0].drain_first && replies_q.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (gap_count < cmd_q[0].gap) begin
        gap_count++;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tdata  <= {PadW'(0), cmd_q[0].key, cmd_q[0].cmd};
        s_axis_tvalid <= 1'b1;
        void'(cmd_q.pop_front());
        gap_count = 0;
      end
    end
  end

  // receiver: stall a random number of cycles per result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        rx_seen++;
        if (rx_seen % 128 == 0) begin
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        stall_target = rx_calm ? 0 : $urandom_range(0, 15);
        stall_count  = 0;
      end
      if (stall_count < stall_target) begin
        stall_count++;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic queue_cmd(input cmd_e cmd, input logic [KeyW-1:0] key, input bit drain);
    set_cmd_t c;
    c.cmd         = cmd;
    c.key         = key;
    c.gap         = phase_calm ? 0 : $urandom_range(0, 15);
    c.drain_first = drain;
    cmd_q.push_back(c);
  endtask

  // randomize the bytes behind the first zero byte
  function automatic logic [KeyW-1:0] garble_tail(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    bit              past;
    r    = k;
    past = 1'b0;
    for (int b = 0; b < KeyW / 8; b++) begin
      if (past) begin
        r[8*b +: 8] = 8'($urandom);
      end else if (k[8*b +: 8] == 8'd0) begin
        past = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [KeyW-1:0] random_key();
    logic [KeyW-1:0] k;
    int unsigned     r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      k = key_pool[$urandom_range(0, PoolSize - 1)];
      if ($urandom_range(0, 1) == 1) begin
        k = garble_tail(k);
      end
    end else if (r == 7) begin
      k = {$urandom, $urandom};
    end else if (r == 8) begin
      k = {$urandom, $urandom};
      k[8*$urandom_range(0, 7) +: 8] = 8'd0;
    end else begin
      k = ($urandom_range(0, 1) == 1) ? '1 : garble_tail('0);
    end
    return k;
  endfunction

  function automatic cmd_e pick_cmd(input int unsigned mode);
    int unsigned r;
    int unsigned ins_lim;
    int unsigned rem_lim;
    r       = $urandom_range(0, 99);
    ins_lim = (mode == 0) ? 55 : (mode == 1) ? 15 : 35;
    rem_lim = (mode == 0) ? 70 : 65;
    if (r < ins_lim) begin
      return CMD_INSERT;
    end else if (r < rem_lim) begin
      return CMD_REMOVE;
    end else if (r < 95) begin
      return CMD_LOOKUP;
    end
    return CMD_SPARE;
  endfunction

  initial begin
    int unsigned len;
    int unsigned mode;
    for (int p = 0; p < PoolSize; p++) begin
      key_pool[p] = '0;
      len = $urandom_range(1, 8);
      for (int b = 0; b < len; b++) begin
        key_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
      end
    end

    queue_cmd(CMD_LOOKUP, 64'h41, 1'b0);
    queue_cmd(CMD_REMOVE, 64'h41, 1'b0);
    queue_cmd(CMD_INSERT, '0, 1'b0);
    queue_cmd(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 1'b0);
    queue_cmd(CMD_INSERT, '1, 1'b0);
    queue_cmd(CMD_INSERT, '1, 1'b0);
    queue_cmd(CMD_INSERT, 64'h1234_0000_0000_0041, 1'b0);
    queue_cmd(CMD_LOOKUP, 64'h41, 1'b0);
    queue_cmd(CMD_SPARE, 64'h41, 1'b0);
    queue_cmd(CMD_SPARE, 64'h42, 1'b0);
    queue_cmd(CMD_REMOVE, '0, 1'b0);
    for (int p = 0; p < 14; p++) begin
      queue_cmd(CMD_INSERT, key_pool[p], 1'b0);
    end
    queue_cmd(CMD_INSERT, 64'h41, 1'b1);
    queue_cmd(CMD_INSERT, key_pool[14], 1'b0);
    queue_cmd(CMD_REMOVE, key_pool[5], 1'b0);
    queue_cmd(CMD_REMOVE, key_pool[5], 1'b0);
    queue_cmd(CMD_REMOVE, key_pool[13], 1'b0);

    for (int p = 0; p < NumPhases; p++) begin
      mode       = $urandom_range(0, 2);
      phase_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PhaseLen; i++) begin
        queue_cmd(pick_cmd(mode), random_key(), (p % 3 == 0) && (i == 0));
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_q.size() != 0 || s_axis_tvalid) begin
      @(posedge clk_i);
    end
    while (replies_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
